@@ hdl/fer_pkg.sv @@
package fer_pkg;

   localparam int NUM_SETS  = 7;
   localparam int HALF_SETS = 3;

   localparam int GAIN_W     = 24;
   localparam int LIMIT_W    = 15;
   localparam int RULES_AB_W = 63;
   localparam int RULES_C_W  = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 63;
   localparam int DRIVE_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ERROR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_CHANGE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_FIRST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_SECOND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RULES_THIRD  = 3'd5;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd65536;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32767;

   // Q16 membership arithmetic
   localparam int FRAC_W  = 16;
   localparam int MU_W    = 17;
   localparam int SET_W   = 3;
   localparam int SETP_W  = 4;
   localparam int XS_W    = 19;
   localparam int SAT_Q16 = 196608;
   localparam logic [MU_W-1:0] ONE_Q16 = 17'd65536;
   localparam logic [XS_W-1:0] XS_MAX  = 19'd393216;
   localparam logic [XS_W-1:0] XS_MID  = 19'd196608;

   // rule table
   localparam int RULE_W    = 3;
   localparam int RULE_IDX_W = 6;
   localparam int TABLE_W   = RULES_AB_W + RULES_AB_W + RULES_C_W;
   localparam logic [RULE_W-1:0] RULE_MIN_CODE = 3'b100;

   // shared multiplier and accumulation
   localparam int MUL_A_W = 25;
   localparam int MUL_B_MIN_W = 18;
   localparam int PROD_W  = 34;
   localparam int ACC_W   = 36;
   localparam int MAG_W   = 34;
   localparam int SPLIT_W = 17;
   localparam int LP_W    = 32;
   localparam int SCALE_W = 49;
   localparam int QUO_W   = 17;
   localparam logic [SCALE_W-1:0] ROUND_HALF = 49'h1_8000_0000;
   localparam logic [QUO_W-1:0] RECIP_THIRD = 17'd43691;
   localparam int RECIP_SHIFT = 17;

   typedef struct packed {
      logic [SET_W-1:0]  k;
      logic [FRAC_W-1:0] f;
   } fuzz_type;

   typedef logic [TABLE_W-1:0] table_type;

   function automatic logic [RULE_W-1:0] rule_pick(input table_type tbl,
                                                   input logic [RULE_IDX_W-1:0] idx);
      logic [7:0] pos;
      pos = 8'({2'b00, idx} * 8'd3);
      return tbl[pos +: RULE_W];
   endfunction

endpackage

@@ hdl/fuzzy_error_rate_controller.sv @@
// Two-input fuzzy controller over a 7x7 rule table.
// req channel: req_valid/req_stall with req_setpoint and req_measured. An item
// transfers at a clock edge with req_valid high and req_stall low.
// rsp channel: rsp_valid/rsp_stall with rsp_drive and rsp_limited, one result
// per request, in order.
// csr port: csr_wr_en, csr_index, csr_wdata; gains (Q8.16), drive limit and the
// three rule words. Write only while no request is in flight.
// Each request runs through one shared multiplier under a sequencer: error
// gain, change gain, four rule weights (multiply then accumulate), two limit
// partial products, rounding and a divide by three via reciprocal. req_stall
// stays high from the request transfer until the result is registered, so a new
// request is not taken before the previous one has run through every step.
// The result sits in an output register; the next request can transfer while
// it waits. If rsp_stall holds the result when the next one is done, the
// sequencer waits in its last step until the output register frees up.
// Reset (synchronous, active high) clears the previous error, restores the
// register defaults and drops rsp_valid.
module fuzzy_error_rate_controller #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_measured,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [fer_pkg::DRIVE_W-1:0] rsp_drive,
   output logic                             rsp_limited,
   input  logic                             csr_wr_en,
   input  logic [fer_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fer_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ERR_W = SAMPLE_WIDTH + 1;
   localparam int CHG_W = SAMPLE_WIDTH + 2;
   localparam int MUL_B_W = (CHG_W > fer_pkg::MUL_B_MIN_W) ? CHG_W : fer_pkg::MUL_B_MIN_W;
   localparam int MUL_A_W = fer_pkg::MUL_A_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_GAIN_E = 4'd1;
   localparam logic [3:0] ST_GAIN_D = 4'd2;
   localparam logic [3:0] ST_WMUL   = 4'd3;
   localparam logic [3:0] ST_WACC   = 4'd4;
   localparam logic [3:0] ST_LIM_LO = 4'd5;
   localparam logic [3:0] ST_LIM_HI = 4'd6;
   localparam logic [3:0] ST_ROUND  = 4'd7;
   localparam logic [3:0] ST_DIV    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;

   logic [fer_pkg::GAIN_W-1:0]     gain_e_ff, gain_d_ff;
   logic [fer_pkg::LIMIT_W-1:0]    limit_ff;
   logic [fer_pkg::RULES_AB_W-1:0] rules_a_ff, rules_b_ff;
   logic [fer_pkg::RULES_C_W-1:0]  rules_c_ff;

   logic signed [ERR_W-1:0] err_ff, prev_ff;
   logic signed [CHG_W-1:0] chg_ff;
   fer_pkg::fuzz_type       fz_e_ff, fz_d_ff, fz;

   logic [fer_pkg::PROD_W-1:0]    prod_ff;
   logic [1:0]                    rmag_ff;
   logic                          rneg_ff;
   logic signed [fer_pkg::ACC_W-1:0] acc_ff;
   logic [fer_pkg::SCALE_W-1:0]   scale_ff;
   logic [fer_pkg::QUO_W-1:0]     quo_ff;

   logic                          rsp_valid_ff;
   logic signed [fer_pkg::DRIVE_W-1:0] drive_ff;
   logic                          limited_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic [fer_pkg::MU_W-1:0]   mu_e, mu_d;
   logic [fer_pkg::SETP_W-1:0] set_i, set_j;
   logic [fer_pkg::RULE_IDX_W-1:0] rule_idx;
   logic [fer_pkg::RULE_W-1:0] rule_raw;
   logic [1:0]                 rmag;
   logic                       rneg;
   logic [fer_pkg::ACC_W-1:0]  term;
   logic [fer_pkg::ACC_W-1:0]  acc_abs;
   logic [fer_pkg::MAG_W-1:0]  acc_mag;
   logic [fer_pkg::SCALE_W-1:0] rounded;
   logic [fer_pkg::LIMIT_W-1:0] quo;
   logic [fer_pkg::LIMIT_W-1:0] quo_clip;
   logic                        hit;
   logic                        out_free;

   fer_mul #(
      .A_W(MUL_A_W),
      .B_W(MUL_B_W)
   ) u_mul (
      .a(mul_a),
      .b(mul_b),
      .p(mul_p)
   );

   fer_fuzz #(
      .P_W(MUL_P_W)
   ) u_fuzz (
      .x (mul_p),
      .fz(fz)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;
   assign rsp_limited = limited_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // membership pair for the current weight step
   assign mu_e  = cnt_ff[1] ? {1'b0, fz_e_ff.f} : fer_pkg::ONE_Q16 - {1'b0, fz_e_ff.f};
   assign mu_d  = cnt_ff[0] ? {1'b0, fz_d_ff.f} : fer_pkg::ONE_Q16 - {1'b0, fz_d_ff.f};
   assign set_i = {1'b0, fz_e_ff.k} + fer_pkg::SETP_W'(cnt_ff[1]);
   assign set_j = {1'b0, fz_d_ff.k} + fer_pkg::SETP_W'(cnt_ff[0]);
   assign rule_idx = fer_pkg::RULE_IDX_W'({3'b000, set_i[2:0]} * 6'd7 + {3'b000, set_j[2:0]});
   assign rule_raw = fer_pkg::rule_pick({rules_c_ff, rules_b_ff, rules_a_ff}, rule_idx);

   // out-of-range set only ever carries zero weight; minus four reads as minus three
   always_comb begin
      if (set_i >= fer_pkg::SETP_W'(fer_pkg::NUM_SETS) ||
          set_j >= fer_pkg::SETP_W'(fer_pkg::NUM_SETS)) begin
         rmag = 2'd0;
         rneg = 1'b0;
      end else if (rule_raw == fer_pkg::RULE_MIN_CODE) begin
         rmag = 2'd3;
         rneg = 1'b1;
      end else if (rule_raw[2]) begin
         rmag = 2'(-rule_raw);
         rneg = 1'b1;
      end else begin
         rmag = rule_raw[1:0];
         rneg = 1'b0;
      end
   end

   assign term = (rmag_ff[1] ? {1'b0, prod_ff, 1'b0} : '0) +
                 (rmag_ff[0] ? {2'b00, prod_ff} : '0);
   assign acc_abs = acc_ff[fer_pkg::ACC_W-1] ? fer_pkg::ACC_W'(-acc_ff) : acc_ff;
   assign acc_mag = acc_abs[fer_pkg::MAG_W-1:0];
   assign rounded = scale_ff + fer_pkg::ROUND_HALF;
   assign quo = mul_p[fer_pkg::RECIP_SHIFT+fer_pkg::LIMIT_W-1:fer_pkg::RECIP_SHIFT];
   assign hit = (quo >= limit_ff);
   assign quo_clip = hit ? limit_ff : quo;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_GAIN_E: begin
            mul_a = {1'b0, gain_e_ff};
            mul_b = MUL_B_W'(err_ff);
         end
         ST_GAIN_D: begin
            mul_a = {1'b0, gain_d_ff};
            mul_b = MUL_B_W'(chg_ff);
         end
         ST_WMUL: begin
            mul_a = MUL_A_W'(mu_e);
            mul_b = MUL_B_W'(mu_d);
         end
         ST_LIM_LO: begin
            mul_a = MUL_A_W'(acc_mag[fer_pkg::SPLIT_W-1:0]);
            mul_b = MUL_B_W'(limit_ff);
         end
         ST_LIM_HI: begin
            mul_a = MUL_A_W'(acc_mag[fer_pkg::MAG_W-1:fer_pkg::SPLIT_W]);
            mul_b = MUL_B_W'(limit_ff);
         end
         ST_DIV: begin
            mul_a = MUL_A_W'(quo_ff);
            mul_b = MUL_B_W'(fer_pkg::RECIP_THIRD);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_GAIN_E;
            end
         end
         ST_GAIN_E: state_in = ST_GAIN_D;
         ST_GAIN_D: begin
            state_in = ST_WMUL;
            cnt_in = 2'd0;
         end
         ST_WMUL: state_in = ST_WACC;
         ST_WACC: begin
            cnt_in = cnt_ff + 2'd1;
            state_in = (cnt_ff == 2'd3) ? ST_LIM_LO : ST_WMUL;
         end
         ST_LIM_LO: state_in = ST_LIM_HI;
         ST_LIM_HI: state_in = ST_ROUND;
         ST_ROUND: state_in = ST_DIV;
         ST_DIV: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_e_ff <= fer_pkg::GAIN_RESET;
         gain_d_ff <= fer_pkg::GAIN_RESET;
         limit_ff <= fer_pkg::LIMIT_RESET;
         rules_a_ff <= '0;
         rules_b_ff <= '0;
         rules_c_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fer_pkg::CSR_GAIN_ERROR:   gain_e_ff <= csr_wdata[fer_pkg::GAIN_W-1:0];
            fer_pkg::CSR_GAIN_CHANGE:  gain_d_ff <= csr_wdata[fer_pkg::GAIN_W-1:0];
            fer_pkg::CSR_DRIVE_LIMIT:  limit_ff <= csr_wdata[fer_pkg::LIMIT_W-1:0];
            fer_pkg::CSR_RULES_FIRST:  rules_a_ff <= csr_wdata;
            fer_pkg::CSR_RULES_SECOND: rules_b_ff <= csr_wdata;
            fer_pkg::CSR_RULES_THIRD:  rules_c_ff <= csr_wdata[fer_pkg::RULES_C_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (state_ff == ST_GAIN_E) begin
         prev_ff <= err_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            err_ff <= ERR_W'(req_setpoint) - ERR_W'(req_measured);
            acc_ff <= '0;
         end
         ST_GAIN_E: begin
            fz_e_ff <= fz;
            chg_ff <= CHG_W'(err_ff) - CHG_W'(prev_ff);
         end
         ST_GAIN_D: fz_d_ff <= fz;
         ST_WMUL: begin
            prod_ff <= mul_p[fer_pkg::PROD_W-1:0];
            rmag_ff <= rmag;
            rneg_ff <= rneg;
         end
         ST_WACC: acc_ff <= rneg_ff ? acc_ff - $signed(term) : acc_ff + $signed(term);
         ST_LIM_LO: scale_ff <= fer_pkg::SCALE_W'(mul_p[fer_pkg::LP_W-1:0]);
         ST_LIM_HI: scale_ff <= scale_ff + {mul_p[fer_pkg::LP_W-1:0], {fer_pkg::SPLIT_W{1'b0}}};
         ST_ROUND: quo_ff <= rounded[fer_pkg::SCALE_W-1:fer_pkg::SCALE_W-fer_pkg::QUO_W];
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DIV && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && out_free) begin
         drive_ff <= acc_ff[fer_pkg::ACC_W-1] ? -$signed({1'b0, quo_clip})
                                               : $signed({1'b0, quo_clip});
         limited_ff <= hit;
      end
   end

endmodule

@@ hdl/fer_mul.sv @@
module fer_mul #(
   parameter int A_W = 25,
   parameter int B_W = 18
) (
   input  logic signed [A_W-1:0]     a,
   input  logic signed [B_W-1:0]     b,
   output logic signed [A_W+B_W-1:0] p
);

   assign p = a * b;

endmodule

@@ hdl/fer_fuzz.sv @@
module fer_fuzz #(
   parameter int P_W = 43
) (
   input  logic signed [P_W-1:0] x,
   output fer_pkg::fuzz_type     fz
);

   localparam logic signed [P_W-1:0] SAT_POS = P_W'(fer_pkg::SAT_Q16);
   localparam logic signed [P_W-1:0] SAT_NEG = -SAT_POS;

   logic [fer_pkg::XS_W-1:0] xs;

   // saturate to plus or minus three, then shift up so set 0 sits at zero
   always_comb begin
      if (x > SAT_POS) begin
         xs = fer_pkg::XS_MAX;
      end else if (x < SAT_NEG) begin
         xs = '0;
      end else begin
         xs = x[fer_pkg::XS_W-1:0] + fer_pkg::XS_MID;
      end
   end

   assign fz.k = xs[fer_pkg::XS_W-1:fer_pkg::FRAC_W];
   assign fz.f = xs[fer_pkg::FRAC_W-1:0];

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam longint UNIT_Q16   = 64'd65536;
   localparam longint SCALED_MAX = fer_pkg::HALF_SETS * UNIT_Q16;
   localparam longint WEIGHT_DEN = 64'd3 << 32;
   localparam logic [fer_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [fer_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic signed [fer_pkg::DRIVE_W-1:0] drive;
      logic                               limited;
   } drive_result_type;

   logic                                clock        = 1'b0;
   logic                                reset        = 1'b1;
   logic                                req_valid    = 1'b0;
   logic                                req_stall;
   logic signed [15:0]                  req_setpoint = '0;
   logic signed [15:0]                  req_measured = '0;
   logic                                rsp_valid;
   logic                                rsp_stall    = 1'b0;
   logic signed [fer_pkg::DRIVE_W-1:0]  rsp_drive;
   logic                                rsp_limited;
   logic                                csr_wr_en    = 1'b0;
   logic [fer_pkg::CSR_IDX_W-1:0]       csr_index    = '0;
   logic [fer_pkg::CSR_DATA_W-1:0]      csr_wdata    = '0;

   // predictor copy of the register file and the error history
   logic [fer_pkg::GAIN_W-1:0]     gain_err_q = fer_pkg::GAIN_RESET;
   logic [fer_pkg::GAIN_W-1:0]     gain_chg_q = fer_pkg::GAIN_RESET;
   logic [fer_pkg::LIMIT_W-1:0]    limit_q    = fer_pkg::LIMIT_RESET;
   logic [fer_pkg::RULES_AB_W-1:0] rules_a_q  = '0;
   logic [fer_pkg::RULES_AB_W-1:0] rules_b_q  = '0;
   logic [fer_pkg::RULES_C_W-1:0]  rules_c_q  = '0;
   longint                         prev_error = 0;

   drive_result_type expected_drive_q[$];
   int fail_count     = 0;
   int checked_count  = 0;
   int sent_count     = 0;
   int settings_count = 0;
   bit gap_on         = 1'b0;
   bit stall_on       = 1'b0;
   int stall_left     = 0;

   fuzzy_error_rate_controller u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drive    (rsp_drive),
      .rsp_limited  (rsp_limited),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void locate_set(input longint raw,
                                      input logic [fer_pkg::GAIN_W-1:0] gain,
                                      output int k, output longint f);
      longint x;
      x = raw * longint'(gain);
      if (x > SCALED_MAX) x = SCALED_MAX;
      if (x < -SCALED_MAX) x = -SCALED_MAX;
      x = x + SCALED_MAX;
      k = int'(x >>> 16);
      f = x & (UNIT_Q16 - 1);
   endfunction

   function automatic longint rule_value(input int idx);
      logic [fer_pkg::TABLE_W-1:0]       tbl;
      logic signed [fer_pkg::RULE_W-1:0] code;
      tbl  = {rules_c_q, rules_b_q, rules_a_q};
      code = tbl[3*idx +: fer_pkg::RULE_W];
      if (code == fer_pkg::RULE_MIN_CODE) return -longint'(fer_pkg::HALF_SETS);
      return longint'(code);
   endfunction

   function automatic drive_result_type predict_drive(input logic signed [15:0] sp, me,
                                                      input longint prev);
      longint err, chg, num, p, mag, q, lim, fa, fb, wa, wb;
      int ka, kb;
      drive_result_type res;
      err = longint'(sp) - longint'(me);
      chg = err - prev;
      locate_set(err, gain_err_q, ka, fa);
      locate_set(chg, gain_chg_q, kb, fb);
      num = 0;
      for (int a = 0; a < 2; a++)
         for (int b = 0; b < 2; b++)
            if (ka + a < fer_pkg::NUM_SETS && kb + b < fer_pkg::NUM_SETS) begin
               wa = a ? fa : UNIT_Q16 - fa;
               wb = b ? fb : UNIT_Q16 - fb;
               num += wa * wb * rule_value((ka + a) * fer_pkg::NUM_SETS + kb + b);
            end
      lim = longint'(limit_q);
      p   = lim * num;
      mag = (p < 0) ? -p : p;
      q   = (mag + WEIGHT_DEN / 2) / WEIGHT_DEN;
      if (q > lim) q = lim;
      res.limited = (q >= lim);
      if (p < 0) q = -q;
      res.drive = q[fer_pkg::DRIVE_W-1:0];
      return res;
   endfunction

   function automatic logic [fer_pkg::GAIN_W-1:0] pick_gain(input int amp);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return fer_pkg::GAIN_RESET;
         default: return fer_pkg::GAIN_W'($urandom_range(98304, 393216) / amp);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // result checker
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drive_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer drive %0d limited %0d",
                                      rsp_drive, rsp_limited));
         end else begin
            want = expected_drive_q.pop_front();
            checked_count++;
            if (rsp_drive !== want.drive || rsp_limited !== want.limited)
               report_mismatch($sformatf("drive exp %0d got %0d, limited exp %0d got %0d",
                                         want.drive, rsp_drive, want.limited, rsp_limited));
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (stall_on && stall_left == 0 && $urandom_range(0, 3) == 0)
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 3);
      if (stall_on && stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_csr(input logic [fer_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fer_pkg::CSR_DATA_W-1:0] value);
      logic [fer_pkg::CSR_DATA_W-1:0] data;
      data = value;
      // junk above the register width must be ignored
      if ($urandom_range(0, 1) == 1) begin
         case (idx)
            fer_pkg::CSR_GAIN_ERROR, fer_pkg::CSR_GAIN_CHANGE:
               data[fer_pkg::CSR_DATA_W-1:fer_pkg::GAIN_W] =
                  (fer_pkg::CSR_DATA_W-fer_pkg::GAIN_W)'({$urandom, $urandom});
            fer_pkg::CSR_DRIVE_LIMIT:
               data[fer_pkg::CSR_DATA_W-1:fer_pkg::LIMIT_W] =
                  (fer_pkg::CSR_DATA_W-fer_pkg::LIMIT_W)'({$urandom, $urandom});
            fer_pkg::CSR_RULES_THIRD:
               data[fer_pkg::CSR_DATA_W-1:fer_pkg::RULES_C_W] =
                  (fer_pkg::CSR_DATA_W-fer_pkg::RULES_C_W)'({$urandom, $urandom});
            default: ;
         endcase
      end
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         fer_pkg::CSR_GAIN_ERROR:   gain_err_q = data[fer_pkg::GAIN_W-1:0];
         fer_pkg::CSR_GAIN_CHANGE:  gain_chg_q = data[fer_pkg::GAIN_W-1:0];
         fer_pkg::CSR_DRIVE_LIMIT:  limit_q    = data[fer_pkg::LIMIT_W-1:0];
         fer_pkg::CSR_RULES_FIRST:  rules_a_q  = data[fer_pkg::RULES_AB_W-1:0];
         fer_pkg::CSR_RULES_SECOND: rules_b_q  = data[fer_pkg::RULES_AB_W-1:0];
         fer_pkg::CSR_RULES_THIRD:  rules_c_q  = data[fer_pkg::RULES_C_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_table(input logic [fer_pkg::TABLE_W-1:0] tbl);
      write_csr(fer_pkg::CSR_RULES_FIRST, tbl[fer_pkg::RULES_AB_W-1:0]);
      write_csr(fer_pkg::CSR_RULES_SECOND,
                tbl[2*fer_pkg::RULES_AB_W-1:fer_pkg::RULES_AB_W]);
      write_csr(fer_pkg::CSR_RULES_THIRD,
                fer_pkg::CSR_DATA_W'(tbl[fer_pkg::TABLE_W-1:2*fer_pkg::RULES_AB_W]));
   endtask

   task automatic send_item(input logic signed [15:0] sp, me);
      int gap;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_setpoint <= sp;
      req_measured <= me;
      do @(posedge clock); while (req_stall);
      expected_drive_q.push_back(predict_drive(sp, me, prev_error));
      prev_error = longint'(sp) - longint'(me);
      sent_count++;
      if (gap_on && $urandom_range(0, 2) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drive_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_item(16'sh7FFF, 16'sh8000);
      send_item(16'sh8000, 16'sh7FFF);
      send_item(16'sd0, 16'sd0);
      send_item(-16'sd1, 16'sd0);
   endtask

   task automatic test_rule_codes();
      logic [fer_pkg::TABLE_W-1:0] tbl;
      int v;
      wait_drained();
      write_table({49{3'b100}});
      send_item(16'sd100, 16'sd0);
      send_item(-16'sd5, 16'sd3);
      wait_drained();
      write_table({49{3'b011}});
      send_item(16'sd7, 16'sd7);
      wait_drained();
      tbl = '0;
      for (int i = 0; i < fer_pkg::NUM_SETS; i++)
         for (int j = 0; j < fer_pkg::NUM_SETS; j++) begin
            v = i + j - 6;
            if (v > 3) v = 3;
            if (v < -3) v = -3;
            tbl[3*(fer_pkg::NUM_SETS*i + j) +: fer_pkg::RULE_W] = fer_pkg::RULE_W'(v);
         end
      write_table(tbl);
      write_csr(fer_pkg::CSR_GAIN_ERROR, fer_pkg::CSR_DATA_W'(24'd8192));
      write_csr(fer_pkg::CSR_GAIN_CHANGE, fer_pkg::CSR_DATA_W'(24'd16384));
      stall_on = 1'b1;
      send_item(16'sd4, 16'sd0);
      send_item(-16'sd3, 16'sd2);
      send_item(16'sd10, 16'sd1);
      send_item(-16'sd20, 16'sd5);
   endtask

   task automatic test_gain_extremes();
      wait_drained();
      write_table(fer_pkg::TABLE_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom}));
      write_csr(fer_pkg::CSR_GAIN_ERROR, '1);
      write_csr(fer_pkg::CSR_GAIN_CHANGE, '1);
      send_item(16'sh7FFF, 16'sh8000);
      send_item(16'sh8000, 16'sh7FFF);
      send_item(16'sd1, 16'sd0);
      wait_drained();
      write_csr(fer_pkg::CSR_GAIN_ERROR, '0);
      write_csr(fer_pkg::CSR_GAIN_CHANGE, '0);
      send_item(16'sd1234, -16'sd999);
      send_item(16'sh8000, 16'sh7FFF);
   endtask

   task automatic test_drive_limit();
      wait_drained();
      write_csr(fer_pkg::CSR_GAIN_ERROR, fer_pkg::CSR_DATA_W'(24'd4096));
      write_csr(fer_pkg::CSR_GAIN_CHANGE, fer_pkg::CSR_DATA_W'(24'd4096));
      write_csr(fer_pkg::CSR_DRIVE_LIMIT, '0);
      send_item(16'sd30, -16'sd10);
      send_item(-16'sd45, 16'sd5);
      wait_drained();
      write_csr(fer_pkg::CSR_DRIVE_LIMIT, fer_pkg::CSR_DATA_W'(15'd1));
      send_item(16'sd40, 16'sd0);
      send_item(-16'sd12, 16'sd7);
      wait_drained();
      write_csr(fer_pkg::CSR_DRIVE_LIMIT, fer_pkg::CSR_DATA_W'(fer_pkg::LIMIT_RESET));
      send_item(16'sd25, -16'sd25);
   endtask

   task automatic test_spare_index();
      wait_drained();
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, '1);
      send_item(16'sd17, 16'sd3);
      send_item(-16'sd9, 16'sd11);
   endtask

   task automatic test_random_phases(input int phases, input int per_phase);
      int amp, step;
      longint target, plant;
      logic signed [15:0] sp, me;
      for (int ph = 0; ph < phases; ph++) begin
         wait_drained();
         case ($urandom_range(0, 2))
            0: amp = 32767;
            1: amp = 512;
            default: amp = 8;
         endcase
         step = amp / 16 + 1;
         write_csr(fer_pkg::CSR_GAIN_ERROR, fer_pkg::CSR_DATA_W'(pick_gain(amp)));
         write_csr(fer_pkg::CSR_GAIN_CHANGE, fer_pkg::CSR_DATA_W'(pick_gain(amp)));
         case ($urandom_range(0, 7))
            0: write_csr(fer_pkg::CSR_DRIVE_LIMIT, '0);
            1: write_csr(fer_pkg::CSR_DRIVE_LIMIT,
                         fer_pkg::CSR_DATA_W'(fer_pkg::LIMIT_RESET));
            2: write_csr(fer_pkg::CSR_DRIVE_LIMIT, fer_pkg::CSR_DATA_W'(15'd1));
            default: write_csr(fer_pkg::CSR_DRIVE_LIMIT,
                               fer_pkg::CSR_DATA_W'($urandom_range(0, 32767)));
         endcase
         write_table(fer_pkg::TABLE_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom}));
         settings_count++;
         gap_on   = (ph % 4) != 0;
         stall_on = (ph % 3) != 0;
         target = 0;
         plant  = 0;
         for (int n = 0; n < per_phase; n++) begin
            // in phase 2, halfway through, the sender holds off until the pipe is empty
            if (ph == 2 && n == per_phase / 2) wait_drained();
            case ($urandom_range(0, 9))
               0, 1: begin
                  sp = 16'($urandom);
                  me = 16'($urandom);
               end
               2: begin
                  sp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                  me = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               end
               default: begin
                  if ($urandom_range(0, 15) == 0)
                     target = longint'($urandom_range(0, 2 * amp)) - amp;
                  plant = plant + (target - plant) / 4
                          + longint'($urandom_range(0, 2 * step)) - step;
                  if (plant > 32767) plant = 32767;
                  if (plant < -32768) plant = -32768;
                  sp = 16'(target);
                  me = 16'(plant);
               end
            endcase
            send_item(sp, me);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_rule_codes();
      test_gain_extremes();
      test_drive_limit();
      test_spare_index();
      test_random_phases(8, 175);
      wait_drained();
      repeat (40) @(posedge clock);
      $display("%0d samples sent, %0d drive results checked, %0d random register settings",
               sent_count, checked_count, settings_count);
      $display("rule codes, saturation, zero gain and limit, spare csr slots: %0d mismatches",
               fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
